/* hw/rtl/i2cbe_pkg.sv */
// Shared types and constants for the I2C master bit engine.
// Holds the command encodings, phase codes, queue sizing and the
// front-to-back queue item; used by every other file of the block.
package i2cbe_pkg;

    // Request codes as they arrive on the tick channel.
    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_START     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STOP      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ_ACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_NACK = 3'd4;

    localparam int BYTE_W = 8;
    localparam int HALF_W = 16;
    localparam int POLL_W = 8;
    localparam int BIT_W  = 4;
    localparam int PH_W   = 3;

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd80;
    localparam logic [POLL_W-1:0] POLL_RESET = 8'd50;
    localparam logic [BIT_W-1:0]  BITS_PER_BYTE = 4'd8;
    localparam logic [POLL_W-1:0] POLL_MAX = 8'hFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL    = 1'b1;
    localparam int CFG_DATA_W = HALF_W;

    // Phase codes. Start uses only the first three and stop only the first two; a read uses
    // code five for its final SCL-low phase.
    localparam logic [PH_W-1:0] PH_SETUP       = 3'd0;
    localparam logic [PH_W-1:0] PH_RISE        = 3'd1;
    localparam logic [PH_W-1:0] PH_FALL        = 3'd2;
    localparam logic [PH_W-1:0] PH_ACK_SETUP   = 3'd3;
    localparam logic [PH_W-1:0] PH_ACK_RISE    = 3'd4;
    localparam logic [PH_W-1:0] PH_POLL        = 3'd5;
    localparam logic [PH_W-1:0] PH_RD_ACK_FALL = 3'd5;
    localparam logic [PH_W-1:0] PH_ACK_FALL    = 3'd6;

    // Queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [4:0] {
        CMD_IDLE  = 5'b00001,
        CMD_START = 5'b00010,
        CMD_STOP  = 5'b00100,
        CMD_WRITE = 5'b01000,
        CMD_READ  = 5'b10000
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;   // CMD_IDLE when the tick carries no command
        logic              nack;
        logic [BYTE_W-1:0] tx;
        logic              sda;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

endpackage

/* hw/rtl/i2cbe_ifs.sv */
// Channel interfaces of the I2C master bit engine: the tick input channel
// and the per-tick result channel. Depends on i2cbe_pkg for field widths.
interface i2cbe_tick_if
    import i2cbe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd_valid;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] tx_byte;
    logic              sda_in;

    modport source (output valid, cmd_valid, req_type, tx_byte, sda_in, input ready);
    modport sink (input valid, cmd_valid, req_type, tx_byte, sda_in, output ready);
endinterface

interface i2cbe_res_if
    import i2cbe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              ready_res;
    logic              cmd_done;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;

    modport source (
        output valid, scl_level, sda_level, sda_drive, ready_res, cmd_done, rx_byte,
               ack_seen,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, sda_drive, ready_res, cmd_done, rx_byte,
               ack_seen,
        output ready
    );
endinterface

/* hw/rtl/i2cbe_front.sv */
// Front end of the I2C master bit engine: decodes each tick item into a
// command class and holds it in a two-entry queue for the back end.
// Depends on i2cbe_pkg and i2cbe_tick_if.
module i2cbe_front
    import i2cbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cbe_tick_if.sink  tick,
    output q_head_t     head,
    input  logic        pop
);

    q_item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    q_item_t              item_new;
    logic                 push;

    // Requests outside the known set, and ticks without a command, become
    // plain timing ticks.
    always_comb
    begin
        item_new.nack = (tick.req_type == REQ_READ_NACK);
        item_new.tx   = tick.tx_byte;
        item_new.sda  = tick.sda_in;
        case (tick.req_type)
            REQ_START:     item_new.cmd = CMD_START;
            REQ_STOP:      item_new.cmd = CMD_STOP;
            REQ_WRITE:     item_new.cmd = CMD_WRITE;
            REQ_READ_ACK:  item_new.cmd = CMD_READ;
            REQ_READ_NACK: item_new.cmd = CMD_READ;
            default:       item_new.cmd = CMD_IDLE;
        endcase
        if (!tick.cmd_valid)
        begin
            item_new.cmd = CMD_IDLE;
        end
    end

    assign tick.ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign push       = tick.valid && tick.ready;
    assign head.valid = (cnt_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    default disable iff (!rst_n);

    // The back end only takes an item that is really there.
    a_pop_nonempty: assert property (@(posedge clk) pop |-> cnt_reg != '0)
        else $error("queue popped while empty");

    // The fill count goes up by one after a push that comes without a pop.
    a_cnt_track: assert property (@(posedge clk)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

/* hw/rtl/i2cbe_back.sv */
// Back end of the I2C master bit engine: the phase sequencer that drives
// SCL and SDA, the configuration registers and the result output register.
// Depends on i2cbe_pkg and i2cbe_res_if.
module i2cbe_back
    import i2cbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  q_head_t               head,
    output logic                  pop,
    i2cbe_res_if.source           res
);

    logic [HALF_W-1:0] half_reg;
    logic [POLL_W-1:0] limit_reg;

    cmd_t              cmd_reg,   cmd_next;
    logic              nack_reg,  nack_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [BIT_W-1:0]  bit_reg,   bit_next;
    logic [HALF_W-1:0] tick_reg,  tick_next;
    logic [POLL_W-1:0] poll_reg,  poll_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              scl_reg,   scl_next;
    logic              sda_reg,   sda_next;
    logic              drv_reg,   drv_next;
    logic              ack_reg,   ack_next;
    logic [BYTE_W-1:0] rx_reg,    rx_next;
    logic              done_next;

    logic              out_vld_reg;
    logic              out_scl_reg;
    logic              out_sda_reg;
    logic              out_drv_reg;
    logic              out_rdy_reg;
    logic              out_done_reg;
    logic [BYTE_W-1:0] out_rx_reg;
    logic              out_ack_reg;

    logic              enter_en;
    logic [PH_W-1:0]   enter_ph;
    logic              fin;
    logic              poll_en;
    logic [POLL_W-1:0] poll_val;
    logic [HALF_W-1:0] tick_inc;
    logic [HALF_W-1:0] len;
    logic [BIT_W-1:0]  bit_inc;

    assign pop = head.valid && (!out_vld_reg || res.ready);

    always_comb
    begin
        cmd_next   = cmd_reg;
        nack_next  = nack_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        poll_next  = poll_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        enter_en   = 1'b0;
        enter_ph   = PH_SETUP;
        fin        = 1'b0;
        poll_en    = 1'b0;
        poll_val   = '0;
        tick_inc   = tick_reg + 1'b1;
        bit_inc    = bit_reg + 1'b1;
        // A zero half period behaves as one tick.
        len        = (half_reg == '0) ? HALF_W'(1) : half_reg;

        if (cmd_reg == CMD_IDLE)
        begin
            if (head.item.cmd != CMD_IDLE)
            begin
                cmd_next  = head.item.cmd;
                nack_next = head.item.nack;
                bit_next  = '0;
                poll_next = '0;
                if (head.item.cmd == CMD_WRITE)
                begin
                    shift_next = head.item.tx;
                    ack_next   = 1'b0;
                end
                else if (head.item.cmd == CMD_READ)
                begin
                    shift_next = '0;
                end
                enter_en = 1'b1;
                enter_ph = PH_SETUP;
            end
        end
        else
        begin
            tick_next = tick_inc;
            if (tick_inc >= len)
            begin
                case (cmd_reg)
                    CMD_START:
                    begin
                        if (phase_reg < PH_FALL)
                        begin
                            enter_en = 1'b1;
                            enter_ph = phase_reg + 1'b1;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    CMD_STOP:
                    begin
                        if (phase_reg < PH_RISE)
                        begin
                            enter_en = 1'b1;
                            enter_ph = phase_reg + 1'b1;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    CMD_WRITE:
                    begin
                        case (phase_reg)
                            PH_SETUP, PH_RISE, PH_ACK_SETUP:
                            begin
                                enter_en = 1'b1;
                                enter_ph = phase_reg + 1'b1;
                            end
                            PH_FALL:
                            begin
                                bit_next = bit_inc;
                                enter_en = 1'b1;
                                enter_ph = (bit_inc < BITS_PER_BYTE) ? PH_SETUP : PH_ACK_SETUP;
                            end
                            PH_ACK_RISE:
                            begin
                                poll_next = '0;
                                poll_val  = '0;
                                poll_en   = 1'b1;
                            end
                            PH_POLL:
                            begin
                                poll_val  = (poll_reg != POLL_MAX) ? poll_reg + 1'b1 : poll_reg;
                                poll_next = poll_val;
                                poll_en   = 1'b1;
                            end
                            default: fin = 1'b1;
                        endcase
                    end
                    CMD_READ:
                    begin
                        case (phase_reg)
                            PH_SETUP, PH_ACK_SETUP, PH_ACK_RISE:
                            begin
                                enter_en = 1'b1;
                                enter_ph = phase_reg + 1'b1;
                            end
                            PH_RISE:
                            begin
                                // Sample SDA at the end of the SCL-high phase.
                                shift_next = {shift_reg[BYTE_W-2:0], head.item.sda};
                                enter_en   = 1'b1;
                                enter_ph   = PH_FALL;
                            end
                            PH_FALL:
                            begin
                                bit_next = bit_inc;
                                enter_en = 1'b1;
                                enter_ph = (bit_inc < BITS_PER_BYTE) ? PH_SETUP : PH_ACK_SETUP;
                            end
                            default: fin = 1'b1;
                        endcase
                    end
                    default: fin = 1'b1;
                endcase
            end
        end

        // One ACK sample: give up at the limit, stop on a low line, else wait
        // another phase.
        if (poll_en)
        begin
            if (poll_val >= limit_reg)
            begin
                enter_en = 1'b1;
                enter_ph = PH_ACK_FALL;
            end
            else if (!head.item.sda)
            begin
                ack_next = 1'b1;
                enter_en = 1'b1;
                enter_ph = PH_ACK_FALL;
            end
            else
            begin
                phase_next = PH_POLL;
                tick_next  = '0;
            end
        end

        if (enter_en)
        begin
            phase_next = enter_ph;
            tick_next  = '0;
            case (cmd_next)
                CMD_START:
                begin
                    if (enter_ph == PH_SETUP)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    else if (enter_ph == PH_RISE)
                    begin
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                CMD_STOP:
                begin
                    if (enter_ph == PH_SETUP)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        sda_next = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    case (enter_ph)
                        PH_SETUP:
                        begin
                            drv_next   = 1'b1;
                            sda_next   = shift_next[BYTE_W-1];
                            shift_next = {shift_next[BYTE_W-2:0], 1'b0};
                        end
                        PH_RISE, PH_ACK_RISE: scl_next = 1'b1;
                        PH_FALL, PH_ACK_FALL: scl_next = 1'b0;
                        PH_ACK_SETUP:
                        begin
                            drv_next = 1'b0;
                            sda_next = 1'b1;
                        end
                        default: scl_next = scl_reg;
                    endcase
                end
                CMD_READ:
                begin
                    case (enter_ph)
                        PH_SETUP:                scl_next = scl_reg;
                        PH_RISE, PH_ACK_RISE:    scl_next = 1'b1;
                        PH_FALL, PH_RD_ACK_FALL: scl_next = 1'b0;
                        PH_ACK_SETUP:
                        begin
                            drv_next = 1'b1;
                            sda_next = nack_next;
                        end
                        default: scl_next = scl_reg;
                    endcase
                    if (enter_ph == PH_SETUP)
                    begin
                        drv_next = 1'b0;
                    end
                end
                default: scl_next = scl_reg;
            endcase
        end

        if (fin)
        begin
            case (cmd_reg)
                CMD_STOP:  drv_next = 1'b0;
                CMD_WRITE: drv_next = 1'b1;
                CMD_READ:  rx_next  = shift_next;
                default:   rx_next  = rx_reg;
            endcase
            cmd_next   = CMD_IDLE;
            phase_next = PH_SETUP;
            tick_next  = '0;
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= HALF_RESET;
            limit_reg   <= POLL_RESET;
            cmd_reg     <= CMD_IDLE;
            nack_reg    <= 1'b0;
            phase_reg   <= PH_SETUP;
            bit_reg     <= '0;
            tick_reg    <= '0;
            poll_reg    <= '0;
            shift_reg   <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drv_reg     <= 1'b0;
            ack_reg     <= 1'b0;
            rx_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HALF_PERIOD: half_reg  <= cfg_data;
                    CFG_ACK_POLL:    limit_reg <= cfg_data[POLL_W-1:0];
                    default:         half_reg  <= half_reg;
                endcase
            end
            if (pop)
            begin
                cmd_reg     <= cmd_next;
                nack_reg    <= nack_next;
                phase_reg   <= phase_next;
                bit_reg     <= bit_next;
                tick_reg    <= tick_next;
                poll_reg    <= poll_next;
                shift_reg   <= shift_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                drv_reg     <= drv_next;
                ack_reg     <= ack_next;
                rx_reg      <= rx_next;
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_scl_reg  <= scl_next;
            out_sda_reg  <= drv_next ? sda_next : 1'b1;
            out_drv_reg  <= drv_next;
            out_rdy_reg  <= (cmd_next == CMD_IDLE);
            out_done_reg <= done_next;
            out_rx_reg   <= rx_next;
            out_ack_reg  <= ack_next;
        end
    end

    assign res.valid     = out_vld_reg;
    assign res.scl_level = out_scl_reg;
    assign res.sda_level = out_sda_reg;
    assign res.sda_drive = out_drv_reg;
    assign res.ready_res = out_rdy_reg;
    assign res.cmd_done  = out_done_reg;
    assign res.rx_byte   = out_rx_reg;
    assign res.ack_seen  = out_ack_reg;

    default disable iff (!rst_n);

    a_idle_clean: assert property (@(posedge clk)
        cmd_reg == CMD_IDLE |-> (phase_reg == PH_SETUP && tick_reg == '0))
        else $error("idle engine left a phase or tick count behind");

    a_bit_range: assert property (@(posedge clk) bit_reg <= BITS_PER_BYTE)
        else $error("bit counter ran past one byte");

    a_done_idle: assert property (@(posedge clk)
        (out_vld_reg && out_done_reg) |-> out_rdy_reg)
        else $error("command reported done while engine still busy");

    a_frame_drives: assert property (@(posedge clk)
        (cmd_reg == CMD_START || cmd_reg == CMD_STOP) |-> drv_reg)
        else $error("SDA released during a start or stop condition");

endmodule

/* hw/rtl/i2c_master_bit_engine.sv */
// I2C master bit engine: one tick item in, one result item out per cycle.
// An accepted tick waits in a queue entry; the sequencer step then writes its
// result into the output register. Throughput: one tick per cycle when the
// result channel is not stalled, set by the single-step phase sequencer.
// Reset: asynchronous, active low; the engine comes up idle with SCL high,
// SDA released, 80-tick phases and an ACK poll limit of 50.
module i2c_master_bit_engine
    import i2cbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    i2cbe_tick_if.sink            tick,
    i2cbe_res_if.source           res
);

    q_head_t head;
    logic    pop;

    i2cbe_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .head  (head),
        .pop   (pop)
    );

    i2cbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .res       (res)
    );

endmodule

/* dv/tb_top.sv */
// Self-checking bench for the I2C master bit engine: drives tick items, predicts every
// result item in step with the engine and compares them in order.
// Depends on i2cbe_pkg, the channel interfaces and the i2c_master_bit_engine top level.
module tb_top;
    import i2cbe_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 40;

    typedef enum int {
        SDA_RANDOM,
        SDA_HELD_HIGH,
        SDA_HELD_LOW,
        SDA_MOSTLY_HIGH
    } sda_mode_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              sda_oe;
        logic              idle;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              ack;
    } bus_view_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2cbe_tick_if tick_ch();
    i2cbe_res_if  res_ch();

    i2c_master_bit_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .res       (res_ch)
    );

    // Engine shadow state, advanced once per accepted tick item.
    cmd_t              eng_cmd;
    logic              eng_nack;
    logic [PH_W-1:0]   eng_phase;
    logic [BIT_W-1:0]  eng_bits;
    logic [HALF_W-1:0] eng_ticks;
    logic [POLL_W-1:0] eng_polls;
    logic [BYTE_W-1:0] eng_shift;
    logic              eng_scl;
    logic              eng_sda;
    logic              eng_oe;
    logic              eng_ack;
    logic [BYTE_W-1:0] eng_rx;
    logic              eng_done;
    logic [HALF_W-1:0] cfg_half;
    logic [POLL_W-1:0] cfg_polls;

    bus_view_t pending_views[$];

    int gap_pct      = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int results_seen = 0;
    int ticks_sent   = 0;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void model_reset();
        eng_cmd   = CMD_IDLE;
        eng_nack  = 1'b0;
        eng_phase = PH_SETUP;
        eng_bits  = '0;
        eng_ticks = '0;
        eng_polls = '0;
        eng_shift = '0;
        eng_scl   = 1'b1;
        eng_sda   = 1'b1;
        eng_oe    = 1'b0;
        eng_ack   = 1'b0;
        eng_rx    = '0;
        eng_done  = 1'b0;
        cfg_half  = HALF_RESET;
        cfg_polls = POLL_RESET;
    endfunction

    // Sets the line levels that a phase opens with.
    function automatic void go_phase(input logic [PH_W-1:0] p);
        eng_phase = p;
        eng_ticks = '0;
        case (eng_cmd)
            CMD_START:
            begin
                if (p == PH_SETUP)
                begin
                    eng_oe  = 1'b1;
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end
                else if (p == PH_RISE)
                    eng_sda = 1'b0;
                else
                    eng_scl = 1'b0;
            end
            CMD_STOP:
            begin
                if (p == PH_SETUP)
                begin
                    eng_oe  = 1'b1;
                    eng_sda = 1'b0;
                    eng_scl = 1'b1;
                end
                else
                    eng_sda = 1'b1;
            end
            CMD_WRITE:
            begin
                case (p)
                    PH_SETUP:
                    begin
                        eng_oe    = 1'b1;
                        eng_sda   = eng_shift[BYTE_W-1];
                        eng_shift = {eng_shift[BYTE_W-2:0], 1'b0};
                    end
                    PH_RISE, PH_ACK_RISE: eng_scl = 1'b1;
                    PH_FALL, PH_ACK_FALL: eng_scl = 1'b0;
                    PH_ACK_SETUP:
                    begin
                        eng_oe  = 1'b0;
                        eng_sda = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                case (p)
                    PH_SETUP: eng_oe = 1'b0;
                    PH_RISE, PH_ACK_RISE: eng_scl = 1'b1;
                    PH_FALL, PH_RD_ACK_FALL: eng_scl = 1'b0;
                    PH_ACK_SETUP:
                    begin
                        eng_oe  = 1'b1;
                        eng_sda = eng_nack;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic void wrap_up();
        case (eng_cmd)
            CMD_STOP:  eng_oe = 1'b0;
            CMD_WRITE: eng_oe = 1'b1;
            CMD_READ:  eng_rx = eng_shift;
            default: ;
        endcase
        eng_cmd   = CMD_IDLE;
        eng_phase = PH_SETUP;
        eng_ticks = '0;
        eng_done  = 1'b1;
    endfunction

    function automatic void poll_sample(input logic sda);
        if (eng_polls >= cfg_polls)
            go_phase(PH_ACK_FALL);
        else if (!sda)
        begin
            eng_ack = 1'b1;
            go_phase(PH_ACK_FALL);
        end
        else
        begin
            eng_phase = PH_POLL;
            eng_ticks = '0;
        end
    endfunction

    function automatic bus_view_t model_tick(input logic cv, input logic [REQ_W-1:0] req,
                                             input logic [BYTE_W-1:0] tx, input logic sda);
        bus_view_t         view;
        logic [HALF_W-1:0] span;
        span     = (cfg_half == '0) ? 16'd1 : cfg_half;
        eng_done = 1'b0;
        if (eng_cmd == CMD_IDLE)
        begin
            if (cv && req <= REQ_READ_NACK)
            begin
                eng_bits  = '0;
                eng_polls = '0;
                case (req)
                    REQ_START: eng_cmd = CMD_START;
                    REQ_STOP:  eng_cmd = CMD_STOP;
                    REQ_WRITE:
                    begin
                        eng_cmd   = CMD_WRITE;
                        eng_shift = tx;
                        eng_ack   = 1'b0;
                    end
                    default:
                    begin
                        eng_cmd   = CMD_READ;
                        eng_nack  = (req == REQ_READ_NACK);
                        eng_shift = '0;
                    end
                endcase
                go_phase(PH_SETUP);
            end
        end
        else
        begin
            eng_ticks = eng_ticks + 1'b1;
            if (eng_ticks >= span)
            begin
                case (eng_cmd)
                    CMD_START:
                    begin
                        if (eng_phase < PH_FALL)
                            go_phase(eng_phase + 1'b1);
                        else
                            wrap_up();
                    end
                    CMD_STOP:
                    begin
                        if (eng_phase < PH_RISE)
                            go_phase(eng_phase + 1'b1);
                        else
                            wrap_up();
                    end
                    CMD_WRITE:
                    begin
                        case (eng_phase)
                            PH_SETUP, PH_RISE, PH_ACK_SETUP: go_phase(eng_phase + 1'b1);
                            PH_FALL:
                            begin
                                eng_bits = eng_bits + 1'b1;
                                if (eng_bits < BITS_PER_BYTE)
                                    go_phase(PH_SETUP);
                                else
                                    go_phase(PH_ACK_SETUP);
                            end
                            PH_ACK_RISE:
                            begin
                                eng_polls = '0;
                                poll_sample(sda);
                            end
                            PH_POLL:
                            begin
                                if (eng_polls < POLL_MAX)
                                    eng_polls = eng_polls + 1'b1;
                                poll_sample(sda);
                            end
                            default: wrap_up();
                        endcase
                    end
                    CMD_READ:
                    begin
                        case (eng_phase)
                            PH_SETUP, PH_ACK_SETUP, PH_ACK_RISE: go_phase(eng_phase + 1'b1);
                            PH_RISE:
                            begin
                                // SDA is sampled as the SCL-high phase closes.
                                eng_shift = {eng_shift[BYTE_W-2:0], sda};
                                go_phase(PH_FALL);
                            end
                            PH_FALL:
                            begin
                                eng_bits = eng_bits + 1'b1;
                                if (eng_bits < BITS_PER_BYTE)
                                    go_phase(PH_SETUP);
                                else
                                    go_phase(PH_ACK_SETUP);
                            end
                            default: wrap_up();
                        endcase
                    end
                    default: wrap_up();
                endcase
            end
        end
        view.scl    = eng_scl;
        view.sda    = eng_oe ? eng_sda : 1'b1;
        view.sda_oe = eng_oe;
        view.idle   = (eng_cmd == CMD_IDLE);
        view.done   = eng_done;
        view.rx     = eng_rx;
        view.ack    = eng_ack;
        return view;
    endfunction

    function automatic logic pick_sda(input sda_mode_t mode);
        case (mode)
            SDA_HELD_HIGH:   return 1'b1;
            SDA_HELD_LOW:    return 1'b0;
            SDA_MOSTLY_HIGH: return ($urandom_range(7) != 0);
            default:         return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("ERROR: %s", msg);
    endtask

    task automatic send_tick(input logic cv, input logic [REQ_W-1:0] req,
                             input logic [BYTE_W-1:0] tx, input logic sda);
        while ($urandom_range(99) < gap_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.cmd_valid <= cv;
        tick_ch.req_type  <= req;
        tick_ch.tx_byte   <= tx;
        tick_ch.sda_in    <= sda;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        pending_views.push_back(model_tick(cv, req, tx, sda));
        ticks_sent++;
    endtask

    // Plain ticks until the engine goes idle; busy_noise offers commands it must ignore.
    task automatic finish_command(input sda_mode_t mode, input bit busy_noise);
        while (eng_cmd != CMD_IDLE)
            send_tick(busy_noise && ($urandom_range(15) == 0), REQ_W'($urandom_range(7)),
                      BYTE_W'($urandom), pick_sda(mode));
    endtask

    task automatic run_command(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                               input sda_mode_t mode, input bit busy_noise);
        send_tick(1'b1, req, tx, pick_sda(mode));
        finish_command(mode, busy_noise);
    endtask

    // Holds the sender back until every predicted result item has been taken.
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HALF_PERIOD)
            cfg_half = data;
        else
            cfg_polls = data[POLL_W-1:0];
    endtask

    task automatic check_view();
        bus_view_t want;
        string     bad;
        results_seen++;
        if (pending_views.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = pending_views.pop_front();
        bad  = "";
        if (res_ch.scl_level !== want.scl)
            bad = {bad, $sformatf(" scl %b/%b", res_ch.scl_level, want.scl)};
        if (res_ch.sda_level !== want.sda)
            bad = {bad, $sformatf(" sda %b/%b", res_ch.sda_level, want.sda)};
        if (res_ch.sda_drive !== want.sda_oe)
            bad = {bad, $sformatf(" sda_drive %b/%b", res_ch.sda_drive, want.sda_oe)};
        if (res_ch.ready_res !== want.idle)
            bad = {bad, $sformatf(" ready_res %b/%b", res_ch.ready_res, want.idle)};
        if (res_ch.cmd_done !== want.done)
            bad = {bad, $sformatf(" cmd_done %b/%b", res_ch.cmd_done, want.done)};
        if (res_ch.rx_byte !== want.rx)
            bad = {bad, $sformatf(" rx_byte %h/%h", res_ch.rx_byte, want.rx)};
        if (res_ch.ack_seen !== want.ack)
            bad = {bad, $sformatf(" ack_seen %b/%b", res_ch.ack_seen, want.ack)};
        if (bad != "")
            report_mismatch($sformatf("result %0d (got/exp):%s", results_seen, bad));
    endtask

    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && res_ch.valid && res_ch.ready)
            check_view();
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("i2c_master_bit_engine: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // A full START at the reset phase length shows the 80-tick default.
    task automatic test_reset_values();
        gap_pct   = 0;
        stall_pct = 0;
        run_command(REQ_START, 8'h00, SDA_RANDOM, 1'b0);
    endtask

    task automatic test_command_set();
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_ACK_POLL, 16'd3);
        run_command(REQ_STOP, 8'h00, SDA_RANDOM, 1'b0);
        run_command(REQ_START, 8'h00, SDA_RANDOM, 1'b0);
        run_command(REQ_WRITE, 8'hFF, SDA_HELD_LOW, 1'b0);
        run_command(REQ_WRITE, 8'h00, SDA_HELD_HIGH, 1'b0);
        run_command(REQ_READ_ACK, 8'h00, SDA_RANDOM, 1'b0);
        run_command(REQ_READ_NACK, 8'hFF, SDA_HELD_HIGH, 1'b0);
        run_command(REQ_READ_ACK, 8'hFF, SDA_HELD_LOW, 1'b0);
        run_command(3'd5, 8'h55, SDA_RANDOM, 1'b0);
        run_command(3'd6, 8'hAA, SDA_RANDOM, 1'b0);
        run_command(3'd7, 8'hFF, SDA_RANDOM, 1'b0);
        run_command(REQ_WRITE, 8'hA5, SDA_MOSTLY_HIGH, 1'b1);
        run_command(REQ_STOP, 8'h00, SDA_RANDOM, 1'b1);
    endtask

    task automatic test_extreme_settings();
        write_reg(CFG_HALF_PERIOD, 16'd0);
        // Only the low byte reaches the poll limit, so this leaves it at zero.
        write_reg(CFG_ACK_POLL, 16'hFF00);
        run_command(REQ_WRITE, 8'hC3, SDA_HELD_LOW, 1'b0);
        run_command(REQ_READ_NACK, 8'h00, SDA_RANDOM, 1'b0);
        write_reg(CFG_ACK_POLL, 16'd255);
        write_reg(CFG_HALF_PERIOD, 16'd1);
        run_command(REQ_WRITE, 8'h3C, SDA_HELD_HIGH, 1'b0);
    endtask

    task automatic test_register_change_mid_command();
        gap_pct   = 18;
        stall_pct = 18;
        write_reg(CFG_HALF_PERIOD, 16'd3);
        write_reg(CFG_ACK_POLL, 16'd200);
        send_tick(1'b1, REQ_WRITE, 8'h96, 1'b1);
        repeat (5) send_tick(1'b0, REQ_START, 8'h00, 1'b1);
        write_reg(CFG_HALF_PERIOD, 16'hFFFF);
        repeat (6) send_tick(1'b0, REQ_STOP, 8'hFF, 1'b0);
        // The phase is already past the new length, so it closes on the next tick.
        write_reg(CFG_HALF_PERIOD, 16'd2);
        while (!(eng_cmd == CMD_WRITE && eng_phase == PH_POLL && eng_polls >= 4))
            send_tick(1'b0, REQ_START, 8'h00, 1'b1);
        write_reg(CFG_ACK_POLL, 16'd1);
        finish_command(SDA_HELD_HIGH, 1'b1);
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int budget);
        logic [REQ_W-1:0] req;
        int               stop_at;
        gap_pct   = gap;
        stall_pct = stall;
        write_reg(CFG_HALF_PERIOD, CFG_DATA_W'($urandom_range(3)));
        write_reg(CFG_ACK_POLL, ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(255))
                                                         : CFG_DATA_W'($urandom_range(4)));
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
            begin
                if ($urandom_range(1) == 0)
                    send_tick(1'b0, REQ_W'($urandom_range(7)), BYTE_W'($urandom),
                              1'($urandom_range(1)));
                else
                    run_command(REQ_W'($urandom_range(7)), BYTE_W'($urandom),
                                sda_mode_t'($urandom_range(3)), 1'b1);
            end
            else
            begin
                run_command(REQ_START, BYTE_W'($urandom), SDA_RANDOM, 1'($urandom_range(1)));
                repeat ($urandom_range(3, 1))
                begin
                    case ($urandom_range(2))
                        0:       req = REQ_WRITE;
                        1:       req = REQ_READ_ACK;
                        default: req = REQ_READ_NACK;
                    endcase
                    run_command(req, BYTE_W'($urandom), sda_mode_t'($urandom_range(3)),
                                1'($urandom_range(1)));
                end
                run_command(REQ_STOP, BYTE_W'($urandom), SDA_RANDOM, 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        model_reset();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_HALF_PERIOD;
        cfg_data          <= '0;
        tick_ch.valid     <= 1'b0;
        tick_ch.cmd_valid <= 1'b0;
        tick_ch.req_type  <= REQ_START;
        tick_ch.tx_byte   <= '0;
        tick_ch.sda_in    <= 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_command_set();
        test_extreme_settings();
        test_register_change_mid_command();
        test_random_traffic(0, 0, 120);
        test_random_traffic(77, 0, 120);
        test_random_traffic(0, 77, 120);
        test_random_traffic(18, 18, 120);
        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("i2c_master_bit_engine: match");
        else
            $display("i2c_master_bit_engine: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/i2cbe_pkg.sv
hw/rtl/i2cbe_ifs.sv
hw/rtl/i2cbe_front.sv
hw/rtl/i2cbe_back.sv
hw/rtl/i2c_master_bit_engine.sv
dv/tb_top.sv
